// ----- hdl/psa_pkg.sv -----
// shared types and constants of the pixel saturation adjust pipeline
package psa_pkg;

	localparam int ChanW = 8;
	localparam int GainW = 9;

	// saturation divider: (delta << 7) / div, quotient never above 128
	localparam int SatDivW = 9;
	localparam int SatRemW = 17;
	localparam int SatQW = 8;
	localparam int SatStepsPerStage = 2;
	localparam int SatStages = SatQW / SatStepsPerStage;

	// alpha divider: 16384 / a, a in 1..255 (1..128 unless the gain is negative)
	localparam int ADivW = 8;
	localparam int AlphaQW = 15;
	localparam int ARemW = 23;
	localparam int AlphaStepsPerStage = 3;
	localparam int AlphaStages = AlphaQW / AlphaStepsPerStage;
	localparam int AlphaNum = 16384;
	localparam int AlphaBias = 128;

	localparam int AlphaW = 16;
	localparam int DiffW = 9;
	localparam int ProdW = DiffW + AlphaW;
	localparam int ShiftW = ProdW - 7;
	localparam int SumW = ShiftW + 1;

	typedef struct packed {
		logic [ChanW-1:0] red;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] blue;
	} psa_pix_t;

	typedef struct packed {
		psa_pix_t pix;
		logic [ChanW-1:0] light;
		logic gray;
	} psa_ctx_t;

	typedef struct packed {
		logic signed [DiffW-1:0] red;
		logic signed [DiffW-1:0] green;
		logic signed [DiffW-1:0] blue;
	} psa_diff_t;

endpackage

// ----- hdl/psa_ifs.sv -----
// valid/ready channels for input and adjusted pixels
interface psa_in_if import psa_pkg::*; ();
	logic valid;
	logic ready;
	logic [ChanW-1:0] red_in;
	logic [ChanW-1:0] green_in;
	logic [ChanW-1:0] blue_in;

	modport source(output valid, red_in, green_in, blue_in, input ready);
	modport sink(input valid, red_in, green_in, blue_in, output ready);
endinterface

interface psa_out_if import psa_pkg::*; ();
	logic valid;
	logic ready;
	logic [ChanW-1:0] red_out;
	logic [ChanW-1:0] green_out;
	logic [ChanW-1:0] blue_out;

	modport source(output valid, red_out, green_out, blue_out, input ready);
	modport sink(input valid, red_out, green_out, blue_out, output ready);
endinterface

// ----- hdl/psa_sat.sv -----
// front stage (max, min, lightness) and pipelined saturation divider
module psa_sat import psa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_valid,
	input  psa_pix_t         in_pix,
	output logic             out_valid,
	output psa_ctx_t         out_ctx,
	output logic [SatQW-1:0] sat
);

	logic [ChanW-1:0]   mx01, mn01, mx, mn, delta;
	logic [ChanW:0]     sum;
	logic [ChanW-1:0]   light;
	logic [SatDivW-1:0] div;

	// index 0 is the front register, then one per divider stage
	logic               vld_s [SatStages+1];
	psa_ctx_t           ctx_s [SatStages+1];
	logic [SatRemW-1:0] rem_s [SatStages+1];
	logic [SatQW-1:0]   quo_s [SatStages+1];
	logic [SatDivW-1:0] div_s [SatStages+1];

	logic [SatRemW-1:0] rem_nx [SatStages];
	logic [SatQW-1:0]   quo_nx [SatStages];

	always_comb begin
		mx01 = (in_pix.red >= in_pix.green) ? in_pix.red : in_pix.green;
		mx = (mx01 < in_pix.blue) ? in_pix.blue : mx01;
		mn01 = (in_pix.red >= in_pix.green) ? in_pix.green : in_pix.red;
		mn = (mn01 > in_pix.blue) ? in_pix.blue : mn01;
		delta = mx - mn;
		sum = {1'b0, mx} + {1'b0, mn};
		light = sum[ChanW:1];
		div = light[ChanW-1] ? (SatDivW'(510) - sum) : sum;
		if (div == '0) begin
			div = SatDivW'(1);
		end
	end

	// restoring division, two quotient bits per stage
	always_comb begin
		logic [SatRemW-1:0] r;
		logic [SatQW-1:0]   q;
		logic [SatRemW-1:0] dsh;
		for (int g = 0; g < SatStages; g++) begin
			r = rem_s[g];
			q = quo_s[g];
			for (int j = 0; j < SatStepsPerStage; j++) begin
				dsh = SatRemW'(div_s[g]) << (SatQW - 1 - g * SatStepsPerStage - j);
				if (r >= dsh) begin
					r = r - dsh;
					q = {q[SatQW-2:0], 1'b1};
				end else begin
					q = {q[SatQW-2:0], 1'b0};
				end
			end
			rem_nx[g] = r;
			quo_nx[g] = q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g <= SatStages; g++) begin
				vld_s[g] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= in_valid;
			for (int g = 0; g < SatStages; g++) begin
				vld_s[g+1] <= vld_s[g];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s[0] <= '{pix: in_pix, light: light, gray: (delta == '0)};
			rem_s[0] <= {{(SatRemW-ChanW-7){1'b0}}, delta, 7'b0};
			quo_s[0] <= '0;
			div_s[0] <= div;
			for (int g = 0; g < SatStages; g++) begin
				ctx_s[g+1] <= ctx_s[g];
				rem_s[g+1] <= rem_nx[g];
				quo_s[g+1] <= quo_nx[g];
				div_s[g+1] <= div_s[g];
			end
		end
	end

	assign out_valid = vld_s[SatStages];
	assign out_ctx = ctx_s[SatStages];
	assign sat = quo_s[SatStages];

endmodule

// ----- hdl/psa_alpha.sv -----
// gain selection, pipelined 16384/a divider and channel offsets from lightness
module psa_alpha import psa_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     in_valid,
	input  psa_ctx_t                 in_ctx,
	input  logic [SatQW-1:0]         sat,
	input  logic signed [GainW-1:0]  gain,
	output logic                     out_valid,
	output psa_ctx_t                 out_ctx,
	output psa_diff_t                diff,
	output logic signed [AlphaW-1:0] alpha
);

	logic signed [GainW+1:0] gsum;
	logic [ADivW-1:0]        a;

	// index 0 is the selection register, then one per divider stage
	logic                    vld_s [AlphaStages+1];
	psa_ctx_t                ctx_s [AlphaStages+1];
	logic [AlphaQW-1:0]      rem_s [AlphaStages+1];
	logic [AlphaQW-1:0]      quo_s [AlphaStages+1];
	logic [ADivW-1:0]        a_s [AlphaStages+1];
	logic signed [GainW-1:0] gain_s [AlphaStages+1];

	logic [AlphaQW-1:0] rem_nx [AlphaStages];
	logic [AlphaQW-1:0] quo_nx [AlphaStages];

	logic                     vld_sf;
	psa_ctx_t                 ctx_sf;
	psa_diff_t                diff_sf;
	logic signed [AlphaW-1:0] alpha_sf;
	logic signed [AlphaW-1:0] alpha_nx;
	psa_ctx_t                 last_ctx;

	always_comb begin
		gsum = (GainW+2)'(gain) + $signed({3'b0, sat});
		if (gsum >= (GainW+2)'(128)) begin
			a = sat;
		end else begin
			// 0 <= gain < 128 here, or a negative gain whose alpha ignores a
			a = ADivW'(9'd128 - 9'(gain));
		end
		if (a == '0) begin
			a = ADivW'(1);
		end
	end

	// restoring division, three quotient bits per stage
	always_comb begin
		logic [ARemW-1:0]   dsh;
		logic [AlphaQW-1:0] r;
		logic [AlphaQW-1:0] q;
		for (int g = 0; g < AlphaStages; g++) begin
			r = rem_s[g];
			q = quo_s[g];
			for (int j = 0; j < AlphaStepsPerStage; j++) begin
				dsh = ARemW'(a_s[g]) << (AlphaQW - 1 - g * AlphaStepsPerStage - j);
				if (ARemW'(r) >= dsh) begin
					r = AlphaQW'(ARemW'(r) - dsh);
					q = {q[AlphaQW-2:0], 1'b1};
				end else begin
					q = {q[AlphaQW-2:0], 1'b0};
				end
			end
			rem_nx[g] = r;
			quo_nx[g] = q;
		end
	end

	assign last_ctx = ctx_s[AlphaStages];

	always_comb begin
		if (gain_s[AlphaStages] < 0) begin
			alpha_nx = AlphaW'(gain_s[AlphaStages]);
		end else begin
			alpha_nx = $signed({1'b0, quo_s[AlphaStages]}) - AlphaW'(AlphaBias);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g <= AlphaStages; g++) begin
				vld_s[g] <= 1'b0;
			end
			vld_sf <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
			for (int g = 0; g < AlphaStages; g++) begin
				vld_s[g+1] <= vld_s[g];
			end
			vld_sf <= vld_s[AlphaStages];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s[0] <= in_ctx;
			rem_s[0] <= AlphaQW'(AlphaNum);
			quo_s[0] <= '0;
			a_s[0] <= a;
			gain_s[0] <= gain;
			for (int g = 0; g < AlphaStages; g++) begin
				ctx_s[g+1] <= ctx_s[g];
				rem_s[g+1] <= rem_nx[g];
				quo_s[g+1] <= quo_nx[g];
				a_s[g+1] <= a_s[g];
				gain_s[g+1] <= gain_s[g];
			end
			ctx_sf <= last_ctx;
			alpha_sf <= alpha_nx;
			diff_sf.red <= $signed({1'b0, last_ctx.pix.red}) - $signed({1'b0, last_ctx.light});
			diff_sf.green <= $signed({1'b0, last_ctx.pix.green}) - $signed({1'b0, last_ctx.light});
			diff_sf.blue <= $signed({1'b0, last_ctx.pix.blue}) - $signed({1'b0, last_ctx.light});
		end
	end

	assign out_valid = vld_sf;
	assign out_ctx = ctx_sf;
	assign diff = diff_sf;
	assign alpha = alpha_sf;

endmodule

// ----- hdl/psa_mix.sv -----
// per-channel multiply by alpha, floor shift, add back and clamp; gray pixels pass unchanged
module psa_mix import psa_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     in_valid,
	input  psa_ctx_t                 in_ctx,
	input  psa_diff_t                diff,
	input  logic signed [AlphaW-1:0] alpha,
	output logic                     out_valid,
	output psa_pix_t                 out_pix
);

	logic                    vld_s1, vld_s2;
	psa_ctx_t                ctx_s1;
	logic signed [ProdW-1:0] prod_s1 [3];
	psa_pix_t                pix_s2;
	logic [ChanW-1:0]        res [3];
	logic [ChanW-1:0]        chan [3];

	function automatic logic [ChanW-1:0] adjust(input logic [ChanW-1:0] c,
			input logic signed [ProdW-1:0] p);
		logic [SumW-1:0] v;
		logic [ChanW-1:0] o;
		// upper product bits are the arithmetic shift right by 7
		v = {{(SumW-ChanW){1'b0}}, c} + {p[ProdW-1], p[ProdW-1:7]};
		if (v[SumW-1]) begin
			o = '0;
		end else if (|v[SumW-2:ChanW]) begin
			o = '1;
		end else begin
			o = v[ChanW-1:0];
		end
		return o;
	endfunction

	assign chan[0] = ctx_s1.pix.red;
	assign chan[1] = ctx_s1.pix.green;
	assign chan[2] = ctx_s1.pix.blue;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			res[i] = ctx_s1.gray ? chan[i] : adjust(chan[i], prod_s1[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s1 <= in_ctx;
			prod_s1[0] <= ProdW'(diff.red) * ProdW'(alpha);
			prod_s1[1] <= ProdW'(diff.green) * ProdW'(alpha);
			prod_s1[2] <= ProdW'(diff.blue) * ProdW'(alpha);
			pix_s2 <= '{red: res[0], green: res[1], blue: res[2]};
		end
	end

	assign out_valid = vld_s2;
	assign out_pix = pix_s2;

endmodule

// ----- hdl/pixel_saturation_adjust_unit.sv -----
// Pixel saturation adjust, top level.
// One RGB pixel (8 bits per channel) enters on pix per handshake word and
// one adjusted pixel leaves on adj. Lightness and HSL saturation are found,
// the gain register cfg_wdata (signed, 1/128 units) is turned into alpha,
// and each channel moves away from or toward the lightness by alpha/128,
// clamped to 0..255. Gray pixels pass unchanged.
// Throughput: one pixel per clock while adj takes them; a new word can be
// accepted every cycle while the skid register is empty. The result is
// presented on adj after the two restoring dividers (saturation, two bits
// per stage, and 16384/a, three bits per stage), the multiply and clamp
// stages and the output register.
// cfg_we writes the gain; change it only while no pixel is in flight.
// Reset clears all valid bits, those of the output and skid registers too,
// and sets the gain to 0. When adj stalls, the pipeline still moves one more
// word into a skid register, then pix.ready drops and the whole pipeline
// holds; nothing is dropped or repeated.
module pixel_saturation_adjust_unit import psa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	psa_in_if.sink           pix,
	psa_out_if.source        adj,
	input  logic             cfg_we,
	input  logic [GainW-1:0] cfg_wdata
);

	logic signed [GainW-1:0] sat_gain_q;

	logic adv;

	logic             sat_valid;
	psa_ctx_t         sat_ctx;
	logic [SatQW-1:0] sat;

	logic                     alp_valid;
	psa_ctx_t                 alp_ctx;
	psa_diff_t                alp_diff;
	logic signed [AlphaW-1:0] alpha;

	logic     mix_valid;
	psa_pix_t mix_pix;

	logic     out_vld_q, sk_vld_q;
	psa_pix_t out_pix_q, sk_pix_q;

	psa_pix_t in_pix;

	assign in_pix = '{red: pix.red_in, green: pix.green_in, blue: pix.blue_in};

	// pipeline moves whenever the skid register is free
	assign adv = !sk_vld_q;
	assign pix.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_gain_q <= '0;
		end else if (cfg_we) begin
			sat_gain_q <= cfg_wdata;
		end
	end

	psa_sat u_sat (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (pix.valid),
		.in_pix    (in_pix),
		.out_valid (sat_valid),
		.out_ctx   (sat_ctx),
		.sat       (sat)
	);

	psa_alpha u_alpha (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (sat_valid),
		.in_ctx    (sat_ctx),
		.sat       (sat),
		.gain      (sat_gain_q),
		.out_valid (alp_valid),
		.out_ctx   (alp_ctx),
		.diff      (alp_diff),
		.alpha     (alpha)
	);

	psa_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (alp_valid),
		.in_ctx    (alp_ctx),
		.diff      (alp_diff),
		.alpha     (alpha),
		.out_valid (mix_valid),
		.out_pix   (mix_pix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			sk_vld_q <= 1'b0;
		end else if (adj.ready || !out_vld_q) begin
			out_vld_q <= sk_vld_q | mix_valid;
			sk_vld_q <= 1'b0;
		end else if (adv && mix_valid) begin
			sk_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adj.ready || !out_vld_q) begin
			out_pix_q <= sk_vld_q ? sk_pix_q : mix_pix;
		end else if (adv) begin
			sk_pix_q <= mix_pix;
		end
	end

	assign adj.valid = out_vld_q;
	assign adj.red_out = out_pix_q.red;
	assign adj.green_out = out_pix_q.green;
	assign adj.blue_out = out_pix_q.blue;

endmodule
